>>> rtl/core/smam_pkg.sv
// Package for the SPI memory access master.
// Holds opcodes, command bytes and the control/status types shared by the controller and the datapath.
// No dependencies.
package smam_pkg;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CFG_W   = 2;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned SHIFT_W = 40;
	localparam int unsigned REM_W   = 6;

	localparam logic [OP_W-1:0] OP_READ_START  = 3'd0;
	localparam logic [OP_W-1:0] OP_READ_NEXT   = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_END    = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE_START = 3'd3;
	localparam logic [OP_W-1:0] OP_WRITE_DATA  = 3'd4;
	localparam logic [OP_W-1:0] OP_ENABLE      = 3'd5;
	localparam logic [OP_W-1:0] OP_DISABLE     = 3'd6;

	localparam logic [CIDX_W-1:0] REG_ADDR_BYTES = 2'd0;
	localparam logic [CIDX_W-1:0] REG_DATA_BYTES = 2'd1;
	localparam logic [CIDX_W-1:0] REG_CS_LEVEL   = 2'd2;

	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] CMD_WRITE = 8'h02;

	localparam logic [1:0] ADDR_BYTES_RST = 2'd2;
	localparam logic [1:0] DATA_BYTES_RST = 2'd0;

	typedef enum logic [2:0] {
		FK_NONE,
		FK_SEL,
		FK_SHIFT,
		FK_READ,
		FK_REL,
		FK_DIS
	} frame_kind_t;

	typedef enum logic [2:0] {
		LD_NONE,
		LD_START_RD,
		LD_START_WR,
		LD_WRITE,
		LD_READ
	} load_kind_t;

	typedef struct packed {
		load_kind_t  load;
		logic        set_cs;
		logic        fire;
		frame_kind_t kind;
		logic        last;
		logic        valid;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       out_free;
		logic [1:0] addr_bytes_m1;
		logic [1:0] data_bytes_m1;
	} dp_stat_t;

endpackage

>>> rtl/core/smam_if.sv
// Channel interfaces of the SPI memory access master: bus operations in, pin frames out.
// Depends on smam_pkg for field widths.
interface smam_op_if;
	logic                           valid;
	logic                           ready;
	logic [smam_pkg::OP_W-1:0]      opcode;
	logic [smam_pkg::WORD_W-1:0]    address;
	logic [smam_pkg::WORD_W-1:0]    write_word;
	logic [smam_pkg::WORD_W-1:0]    miso_stream;

	modport source (output valid, opcode, address, write_word, miso_stream, input ready);
	modport sink   (input valid, opcode, address, write_word, miso_stream, output ready);
endinterface

interface smam_frame_if;
	logic                           valid;
	logic                           ready;
	logic                           cs_level;
	logic                           mosi_bit;
	logic                           clock_pulse;
	logic [smam_pkg::WORD_W-1:0]    read_data;
	logic                           data_valid;
	logic                           last;

	modport source (output valid, cs_level, mosi_bit, clock_pulse, read_data, data_valid, last,
		input ready);
	modport sink   (input valid, cs_level, mosi_bit, clock_pulse, read_data, data_valid, last,
		output ready);
endinterface

>>> rtl/core/spi_memory_access_master_core.sv
// Top level of the SPI memory access master: controller plus datapath.
// Depends on smam_pkg, smam_if, smam_ctrl and smam_dp.
//
// Each accepted operation yields its pin frames at one frame per clock cycle, while the
// output is not stalled, from a single bit serializer: a start gives a select frame and
// 8 * (address_bytes_minus_one + 2) shifted frames, a read or write data access
// 8 * (data_bytes_minus_one + 1) frames, a read end one release frame more, a disable
// one frame and an enable none. The next operation is accepted the cycle after the
// final frame enters the output register, even while that frame still waits to be
// taken; a stalled output holds the serializer until the register frees up.
module spi_memory_access_master_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [smam_pkg::CIDX_W-1:0]  wr_index,
	input  logic [smam_pkg::CFG_W-1:0]   wr_data,
	smam_op_if.sink                      op,
	smam_frame_if.source                 frame
);
	import smam_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	smam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op.valid),
		.op_ready (op.ready),
		.opcode   (op.opcode),
		.stat     (stat),
		.cmd      (cmd)
	);

	smam_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.address     (op.address),
		.write_word  (op.write_word),
		.miso_stream (op.miso_stream),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (frame.valid),
		.out_ready   (frame.ready),
		.cs_level    (frame.cs_level),
		.mosi_bit    (frame.mosi_bit),
		.clock_pulse (frame.clock_pulse),
		.read_data   (frame.read_data),
		.data_valid  (frame.data_valid),
		.last        (frame.last)
	);

endmodule

>>> rtl/core/smam_ctrl.sv
// Controller state machine of the SPI memory access master.
// Decodes operations and sequences the frames; depends on smam_pkg.
module smam_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      op_valid,
	output logic                      op_ready,
	input  logic [smam_pkg::OP_W-1:0] opcode,
	input  smam_pkg::dp_stat_t        stat,
	output smam_pkg::ctrl_cmd_t       cmd
);
	import smam_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SEL   = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_REL   = 3'd4;
	localparam logic [2:0] ST_DIS   = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] rem_d;
	logic             end_q;
	logic             end_d;
	logic             accept;
	logic [REM_W-1:0] addr_frames_m1;
	logic [REM_W-1:0] data_frames_m1;

	assign op_ready = (state_q == ST_IDLE);
	assign accept   = op_valid && op_ready;

	// Frames of a phase minus one: 8 * bytes - 1.
	assign addr_frames_m1 = {3'({1'b0, stat.addr_bytes_m1}) + 3'd1, 3'b111};
	assign data_frames_m1 = {1'b0, stat.data_bytes_m1, 3'b111};

	always_comb begin
		state_d    = state_q;
		rem_d      = rem_q;
		end_d      = end_q;
		cmd.load   = LD_NONE;
		cmd.set_cs = 1'b0;
		cmd.fire   = 1'b0;
		cmd.kind   = FK_NONE;
		cmd.last   = 1'b0;
		cmd.valid  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_READ_START: begin
							cmd.load = LD_START_RD;
							state_d  = ST_SEL;
						end
						OP_WRITE_START: begin
							cmd.load = LD_START_WR;
							state_d  = ST_SEL;
						end
						OP_WRITE_DATA: begin
							cmd.load = LD_WRITE;
							rem_d    = data_frames_m1;
							state_d  = ST_SHIFT;
						end
						OP_READ_NEXT, OP_READ_END: begin
							cmd.load = LD_READ;
							rem_d    = data_frames_m1;
							end_d    = (opcode == OP_READ_END);
							state_d  = ST_READ;
						end
						OP_ENABLE: cmd.set_cs = 1'b1;
						OP_DISABLE: state_d = ST_DIS;
						default: ;
					endcase
				end
			end
			ST_SEL: begin
				cmd.kind = FK_SEL;
				cmd.fire = stat.out_free;
				if (stat.out_free) begin
					rem_d   = addr_frames_m1;
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.kind = FK_SHIFT;
				cmd.fire = stat.out_free;
				cmd.last = (rem_q == '0);
				if (stat.out_free) begin
					rem_d = rem_q - REM_W'(1);
					if (rem_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_READ: begin
				cmd.kind  = FK_READ;
				cmd.fire  = stat.out_free;
				cmd.last  = (rem_q == '0) && !end_q;
				cmd.valid = (rem_q == '0) && !end_q;
				if (stat.out_free) begin
					rem_d = rem_q - REM_W'(1);
					if (rem_q == '0) begin
						state_d = end_q ? ST_REL : ST_IDLE;
					end
				end
			end
			ST_REL: begin
				cmd.kind  = FK_REL;
				cmd.fire  = stat.out_free;
				cmd.last  = 1'b1;
				cmd.valid = 1'b1;
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIS: begin
				cmd.kind = FK_DIS;
				cmd.fire = stat.out_free;
				cmd.last = 1'b1;
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
			end_q   <= end_d;
		end
	end

endmodule

>>> rtl/core/smam_dp.sv
// Datapath of the SPI memory access master: configuration, shift registers,
// read assembly and the output frame register. Depends on smam_pkg.
module smam_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [smam_pkg::CIDX_W-1:0]  wr_index,
	input  logic [smam_pkg::CFG_W-1:0]   wr_data,
	input  logic [smam_pkg::WORD_W-1:0]  address,
	input  logic [smam_pkg::WORD_W-1:0]  write_word,
	input  logic [smam_pkg::WORD_W-1:0]  miso_stream,
	input  smam_pkg::ctrl_cmd_t          cmd,
	output smam_pkg::dp_stat_t           stat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         cs_level,
	output logic                         mosi_bit,
	output logic                         clock_pulse,
	output logic [smam_pkg::WORD_W-1:0]  read_data,
	output logic                         data_valid,
	output logic                         last
);
	import smam_pkg::*;

	logic [1:0]         addr_bytes_m1_q;
	logic [1:0]         data_bytes_m1_q;
	logic               cs_active_q;
	logic               cs_asserted_q;
	logic               mosi_q;
	logic [SHIFT_W-1:0] sh_q;
	logic [WORD_W-1:0]  miso_q;
	logic [7:0]         byte_q;
	logic [2:0]         bit_cnt_q;
	logic [1:0]         lane_q;
	logic [WORD_W-1:0]  word_q;
	logic [7:0]         byte_next;
	logic [WORD_W-1:0]  word_next;
	logic [WORD_W-1:0]  addr_aligned;
	logic [7:0]         cmd_byte;

	logic               out_valid_q;
	logic               cs_level_q;
	logic               mosi_bit_q;
	logic               clock_pulse_q;
	logic [WORD_W-1:0]  read_data_q;
	logic               data_valid_q;
	logic               last_q;

	logic               f_cs_asserted;
	logic               f_mosi;
	logic               f_clk;
	logic [WORD_W-1:0]  f_data;

	assign stat.out_free      = !out_valid_q || out_ready;
	assign stat.addr_bytes_m1 = addr_bytes_m1_q;
	assign stat.data_bytes_m1 = data_bytes_m1_q;

	// Configuration writes; an index beyond the register list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_bytes_m1_q <= ADDR_BYTES_RST;
			data_bytes_m1_q <= DATA_BYTES_RST;
			cs_active_q     <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ADDR_BYTES: addr_bytes_m1_q <= wr_data;
				REG_DATA_BYTES: data_bytes_m1_q <= wr_data;
				REG_CS_LEVEL:   cs_active_q     <= wr_data[0];
				default: ;
			endcase
		end
	end

	// The address bytes that are sent sit right below the command byte.
	always_comb begin
		unique case (addr_bytes_m1_q)
			2'd0: addr_aligned = {address[7:0], 24'h0};
			2'd1: addr_aligned = {address[15:0], 16'h0};
			2'd2: addr_aligned = {address[23:0], 8'h0};
			default: addr_aligned = address;
		endcase
	end

	assign cmd_byte  = (cmd.load == LD_START_RD) ? CMD_READ : CMD_WRITE;
	assign byte_next = {byte_q[6:0], miso_q[WORD_W-1]};

	always_comb begin
		word_next = word_q;
		for (int i = 0; i < 4; i++) begin
			if (lane_q == 2'(i) && bit_cnt_q == 3'd7) begin
				word_next[i*8 +: 8] = byte_next;
			end
		end
	end

	// Pin levels of the frame being issued this cycle.
	always_comb begin
		f_cs_asserted = cs_asserted_q;
		f_mosi        = mosi_q;
		f_clk         = 1'b0;
		f_data        = '0;
		unique case (cmd.kind)
			FK_SEL: begin
				f_cs_asserted = 1'b1;
				f_mosi        = 1'b0;
			end
			FK_SHIFT: begin
				f_mosi = sh_q[SHIFT_W-1];
				f_clk  = 1'b1;
			end
			FK_READ: begin
				f_mosi = 1'b0;
				f_clk  = 1'b1;
				if (cmd.valid) begin
					f_data = word_next;
				end
			end
			FK_REL: begin
				f_cs_asserted = 1'b0;
				f_data        = word_q;
			end
			FK_DIS: f_cs_asserted = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_asserted_q <= 1'b0;
			mosi_q        <= 1'b0;
		end else begin
			if (cmd.set_cs) begin
				cs_asserted_q <= 1'b1;
			end else if (cmd.fire) begin
				cs_asserted_q <= f_cs_asserted;
				mosi_q        <= f_mosi;
			end
		end
	end

	// Shift registers and read assembly carry payload only.
	always_ff @(posedge clk) begin
		unique case (cmd.load)
			LD_START_RD, LD_START_WR: sh_q <= {cmd_byte, addr_aligned};
			LD_WRITE: sh_q <= {write_word[7:0], write_word[15:8], write_word[23:16],
				write_word[31:24], 8'h0};
			LD_READ: begin
				miso_q    <= miso_stream;
				word_q    <= '0;
				bit_cnt_q <= '0;
				lane_q    <= '0;
			end
			default: begin
				if (cmd.fire && cmd.kind == FK_SHIFT) begin
					sh_q <= {sh_q[SHIFT_W-2:0], 1'b0};
				end
				if (cmd.fire && cmd.kind == FK_READ) begin
					miso_q    <= {miso_q[WORD_W-2:0], 1'b0};
					byte_q    <= byte_next;
					word_q    <= word_next;
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7) begin
						lane_q <= lane_q + 2'd1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			cs_level_q    <= f_cs_asserted ? cs_active_q : !cs_active_q;
			mosi_bit_q    <= f_mosi;
			clock_pulse_q <= f_clk;
			read_data_q   <= f_data;
			data_valid_q  <= cmd.valid;
			last_q        <= cmd.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign cs_level    = cs_level_q;
	assign mosi_bit    = mosi_bit_q;
	assign clock_pulse = clock_pulse_q;
	assign read_data   = read_data_q;
	assign data_valid  = data_valid_q;
	assign last        = last_q;

endmodule

>>> rtl/core/smam_checker.sv
// Port-level checks for the SPI memory access master, bound to the top level.
// Depends on smam_pkg for widths.
module smam_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        frame_valid,
	input logic                        frame_ready,
	input logic                        cs_level,
	input logic                        mosi_bit,
	input logic                        clock_pulse,
	input logic [smam_pkg::WORD_W-1:0] read_data,
	input logic                        data_valid,
	input logic                        last
);
	import smam_pkg::*;

	// A stalled frame transaction keeps its pin levels.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> frame_valid && $stable(cs_level)
			&& $stable(mosi_bit) && $stable(clock_pulse) && $stable(last))
		else $error("frame changed while stalled");

	// A completed read word only ever ends an operation.
	a_valid_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && data_valid |-> last)
		else $error("read word on a frame that is not last");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !data_valid |-> read_data == '0)
		else $error("read data without data valid");

	// The only unclocked frame inside a run is the select frame, which drives MOSI low.
	a_sel_mosi: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !clock_pulse && !last |-> !mosi_bit)
		else $error("select frame with MOSI high");

endmodule

bind spi_memory_access_master_core smam_checker u_smam_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame.valid),
	.frame_ready (frame.ready),
	.cs_level    (frame.cs_level),
	.mosi_bit    (frame.mosi_bit),
	.clock_pulse (frame.clock_pulse),
	.read_data   (frame.read_data),
	.data_valid  (frame.data_valid),
	.last        (frame.last)
);

>>> tb/tb_top.sv
// Self-checking testbench for the SPI memory access master core.
// Predicts every pin frame of each bus operation and compares it field by field.
// Depends on smam_pkg, the channel interfaces and spi_memory_access_master_core.
module tb_top;
	import smam_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 48;
	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int PHASE_OPS = 55;

	typedef struct {
		logic        cs;
		logic        mosi;
		logic        sck;
		logic [31:0] rdata;
		logic        dvalid;
		logic        last;
	} pin_frame_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CIDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	smam_op_if op_bus ();
	smam_frame_if frame_bus ();

	spi_memory_access_master_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.op       (op_bus),
		.frame    (frame_bus)
	);

	always #1 clk = ~clk;

	// Shadow of the block's registers and pin state.
	logic [1:0] addr_m1_cfg;
	logic [1:0] data_m1_cfg;
	logic       cs_level_cfg;
	logic       sel_on;
	logic       mosi_hold;

	pin_frame_t frames_due[$];
	pin_frame_t run_buf[$];

	int          failures = 0;
	int          ops_sent = 0;
	int unsigned cycle_count = 0;
	bit          idle_on = 1'b1;
	bit          stall_on = 1'b1;

	task automatic push_frame(input logic sck, input logic [31:0] rdata, input logic dv);
		pin_frame_t f;
		f.cs = sel_on ? cs_level_cfg : ~cs_level_cfg;
		f.mosi = mosi_hold;
		f.sck = sck;
		f.rdata = rdata;
		f.dvalid = dv;
		f.last = 1'b0;
		run_buf.push_back(f);
	endtask

	task automatic shift_byte(input logic [7:0] b);
		for (int i = 7; i >= 0; i--) begin
			mosi_hold = b[i];
			push_frame(1'b1, '0, 1'b0);
		end
	endtask

	task automatic open_access(input logic [7:0] cmd, input logic [31:0] adr);
		sel_on = 1'b1;
		mosi_hold = 1'b0;
		push_frame(1'b0, '0, 1'b0);
		shift_byte(cmd);
		for (int i = int'(addr_m1_cfg); i >= 0; i--)
			shift_byte(adr[8*i +: 8]);
	endtask

	// Device bits are taken from bit 31 downward; bytes land little-endian.
	task automatic clock_in_word(input logic [31:0] miso, output logic [31:0] word);
		int pos;
		logic [7:0] b;
		pos = 31;
		word = '0;
		for (int i = 0; i <= data_m1_cfg; i++) begin
			b = '0;
			for (int k = 0; k < 8; k++) begin
				mosi_hold = 1'b0;
				b = {b[6:0], miso[pos]};
				pos--;
				push_frame(1'b1, '0, 1'b0);
			end
			word[8*i +: 8] = b;
		end
	endtask

	task automatic forecast_op(input logic [OP_W-1:0] opc, input logic [31:0] adr,
			input logic [31:0] wword, input logic [31:0] miso);
		logic [31:0] word;
		pin_frame_t tail;
		word = '0;
		case (opc)
			OP_READ_START: open_access(CMD_READ, adr);
			OP_READ_NEXT: clock_in_word(miso, word);
			OP_READ_END: begin
				clock_in_word(miso, word);
				sel_on = 1'b0;
				push_frame(1'b0, word, 1'b1);
			end
			OP_WRITE_START: open_access(CMD_WRITE, adr);
			OP_WRITE_DATA: begin
				for (int i = 0; i <= data_m1_cfg; i++)
					shift_byte(wword[8*i +: 8]);
			end
			OP_ENABLE: sel_on = 1'b1;
			OP_DISABLE: begin
				sel_on = 1'b0;
				push_frame(1'b0, '0, 1'b0);
			end
			default: ;
		endcase
		if (run_buf.size() != 0) begin
			tail = run_buf.pop_back();
			if (opc == OP_READ_NEXT) begin
				tail.rdata = word;
				tail.dvalid = 1'b1;
			end
			tail.last = 1'b1;
			run_buf.push_back(tail);
		end
		while (run_buf.size() != 0)
			frames_due.push_back(run_buf.pop_front());
	endtask

	task automatic send_op(input logic [OP_W-1:0] opc, input logic [31:0] adr,
			input logic [31:0] wword, input logic [31:0] miso);
		while (idle_on && $urandom_range(99) < 8) begin
			op_bus.valid <= 1'b0;
			@(posedge clk);
		end
		op_bus.valid <= 1'b1;
		op_bus.opcode <= opc;
		op_bus.address <= adr;
		op_bus.write_word <= wword;
		op_bus.miso_stream <= miso;
		forecast_op(opc, adr, wword, miso);
		if (opc != OP_UNUSED)
			ops_sent++;
		@(posedge clk);
		while (!op_bus.ready)
			@(posedge clk);
	endtask

	// Enable and the unused opcode leave no frame behind, so after the last expected
	// frame the block is given a settling wait before it counts as idle.
	task automatic wait_frames_done();
		op_bus.valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] a_m1, input logic [1:0] d_m1, input logic csl);
		wait_frames_done();
		wr_en <= 1'b1;
		wr_index <= REG_ADDR_BYTES;
		wr_data <= a_m1;
		addr_m1_cfg = a_m1;
		@(posedge clk);
		wr_index <= REG_DATA_BYTES;
		wr_data <= d_m1;
		data_m1_cfg = d_m1;
		@(posedge clk);
		wr_index <= REG_CS_LEVEL;
		wr_data <= {1'b0, csl};
		cs_level_cfg = csl;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin
		pin_frame_t want;
		if (arst_n && frame_bus.valid && frame_bus.ready) begin
			if (frames_due.size() == 0) begin
				failures++;
				$display("%0t: frame with nothing expected, expected none, got cs %b mosi %b",
					$time, frame_bus.cs_level, frame_bus.mosi_bit);
			end else begin
				want = frames_due.pop_front();
				check_field("cs_level", 32'(want.cs), 32'(frame_bus.cs_level));
				check_field("mosi_bit", 32'(want.mosi), 32'(frame_bus.mosi_bit));
				check_field("clock_pulse", 32'(want.sck), 32'(frame_bus.clock_pulse));
				check_field("read_data", want.rdata, frame_bus.read_data);
				check_field("data_valid", 32'(want.dvalid), 32'(frame_bus.data_valid));
				check_field("last", 32'(want.last), 32'(frame_bus.last));
			end
		end
	end

	initial begin
		frame_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			frame_bus.ready <= !(stall_on && $urandom_range(99) < 8);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic test_default_config();
		send_op(OP_READ_START, 32'h0012_3456, '0, '0);
		send_op(OP_READ_NEXT, '0, '0, 32'hA500_0000);
		send_op(OP_READ_END, '0, '0, 32'h5A00_0000);
		send_op(OP_WRITE_START, 32'h00AB_CDEF, '0, '0);
		send_op(OP_WRITE_DATA, '0, 32'h0000_0081, '0);
		send_op(OP_DISABLE, '0, '0, '0);
	endtask

	task automatic test_field_extremes();
		set_config(2'd3, 2'd3, 1'b1);
		send_op(OP_READ_START, 32'hFFFF_FFFF, '0, '0);
		send_op(OP_READ_NEXT, '0, '0, 32'hFFFF_FFFF);
		send_op(OP_READ_END, '0, '0, 32'h0000_0000);
		send_op(OP_WRITE_START, 32'h0000_0000, '0, '0);
		send_op(OP_WRITE_DATA, '0, 32'hFFFF_FFFF, '0);
		send_op(OP_DISABLE, '0, '0, '0);
	endtask

	// Enable with no frame, three-byte words, transfers with select released and
	// the unused opcode.
	task automatic test_select_cases();
		set_config(2'd0, 2'd2, 1'b0);
		send_op(OP_ENABLE, '0, '0, '0);
		send_op(OP_WRITE_DATA, '0, 32'hA5C3_3C5A, '0);
		send_op(OP_READ_NEXT, '0, '0, 32'hC3A5_5A3C);
		send_op(OP_DISABLE, '0, '0, '0);
		send_op(OP_READ_NEXT, '0, '0, 32'h8001_FF00);
		send_op(OP_WRITE_DATA, '0, 32'h1234_5678, '0);
		send_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(OP_READ_START, 32'h8000_0001, '0, '0);
		send_op(OP_READ_END, '0, '0, 32'hDEAD_BEEF);
	endtask

	task automatic run_read_burst();
		int n;
		n = $urandom_range(3);
		if ($urandom_range(9) == 0)
			send_op(OP_ENABLE, $urandom(), $urandom(), $urandom());
		send_op(OP_READ_START, $urandom(), $urandom(), $urandom());
		repeat (n) send_op(OP_READ_NEXT, $urandom(), $urandom(), $urandom());
		send_op(OP_READ_END, $urandom(), $urandom(), $urandom());
	endtask

	task automatic run_write_burst();
		int n;
		n = $urandom_range(4, 1);
		send_op(OP_WRITE_START, $urandom(), $urandom(), $urandom());
		repeat (n) send_op(OP_WRITE_DATA, $urandom(), $urandom(), $urandom());
		send_op(OP_DISABLE, $urandom(), $urandom(), $urandom());
	endtask

	task automatic test_random_traffic();
		int phase_start;
		int pick;
		bit paused;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_config(2'd3, 2'd3, 1'b1);
				1: set_config(2'd0, 2'd0, 1'b0);
				2: set_config(2'd1, 2'd2, 1'b1);
				3: set_config(2'd2, 2'd1, 1'b0);
				default: set_config(2'($urandom_range(3)), 2'($urandom_range(3)),
					1'($urandom_range(1)));
			endcase
			// Phase 1 runs with both sides streaming at full rate.
			idle_on = (p != 1);
			stall_on = (p != 1);
			paused = 1'b0;
			phase_start = ops_sent;
			while (ops_sent - phase_start < PHASE_OPS) begin
				pick = $urandom_range(99);
				if (pick < 45)
					run_read_burst();
				else if (pick < 85)
					run_write_burst();
				else
					repeat ($urandom_range(3, 1))
						send_op(OP_W'($urandom_range(7)), $urandom(), $urandom(), $urandom());
				if (p == 2 && !paused && ops_sent - phase_start > PHASE_OPS / 2) begin
					wait_frames_done();
					paused = 1'b1;
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_ADDR_BYTES;
		wr_data <= '0;
		op_bus.valid <= 1'b0;
		op_bus.opcode <= OP_READ_START;
		op_bus.address <= '0;
		op_bus.write_word <= '0;
		op_bus.miso_stream <= '0;
		addr_m1_cfg = ADDR_BYTES_RST;
		data_m1_cfg = DATA_BYTES_RST;
		cs_level_cfg = 1'b0;
		sel_on = 1'b0;
		mosi_hold = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_config();
		test_field_extremes();
		test_select_cases();
		test_random_traffic();

		wait_frames_done();
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
